[rtl/ppp_pkg.sv]
// types, constants and register codes shared by the point projector
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 64;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int HOM_W     = SUM_W - FRAC_W;
    localparam int MAG_W     = HOM_W - 1;
    localparam int QUO_W     = 32;
    localparam int EXTRA_SH  = FRAC_W + 1;
    localparam int OVF_SH    = QUO_W - EXTRA_SH;

    localparam logic [COORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_C01 = 3'd0,
        CFG_ROW0_C23 = 3'd1,
        CFG_ROW1_C01 = 3'd2,
        CFG_ROW1_C23 = 3'd3,
        CFG_ROW2_C01 = 3'd4,
        CFG_ROW2_C23 = 3'd5
    } t_cfg_idx;

    typedef logic [NUM_CFG-1:0][CFG_W-1:0] t_cfg_regs;

    localparam t_cfg_regs CFG_RESET = {
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic signed [COORD_W-1:0] depth;
        logic                      zero_depth;
    } t_out_word;

    typedef struct packed {
        logic signed [HOM_W-1:0] hx;
        logic signed [HOM_W-1:0] hy;
        logic signed [HOM_W-1:0] hw;
    } t_homog;

    typedef struct packed {
        logic [MAG_W-1:0]   n_x;
        logic [MAG_W-1:0]   n_y;
        logic [MAG_W-1:0]   d;
        logic [MAG_W-1:0]   r_x;
        logic [MAG_W-1:0]   r_y;
        logic [QUO_W-1:0]   q_x;
        logic [QUO_W-1:0]   q_y;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic               zd;
        logic [COORD_W-1:0] depth;
    } t_div_stage;

endpackage

[rtl/ppp_dot.sv]
// matrix times homogeneous point: products, pair sums, final sum with rounding
`timescale 1ns / 1ps

module ppp_dot (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppp_pkg::t_cfg_regs i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppp_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output ppp_pkg::t_homog   o_homog
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   rdy;

    ppp_pkg::t_in_word r_in;
    logic signed [ppp_pkg::PROD_W-1:0] r_prod [3][4];
    logic signed [ppp_pkg::PROD_W-1:0] n_prod [3][4];
    logic [ppp_pkg::PAIR_W-1:0] r_pair [3][2];
    logic [ppp_pkg::PAIR_W-1:0] n_pair [3][2];
    logic [ppp_pkg::SUM_W-1:0]  n_sum [3];
    ppp_pkg::t_homog r_homog;
    ppp_pkg::t_homog n_homog;

    assign rdy[NSTG] = i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end
    assign o_ready = rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_homog = r_homog;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_prod[r][0] = $signed(i_cfg[2*r][31:0]) * r_in.point_x;
            n_prod[r][1] = $signed(i_cfg[2*r][63:32]) * r_in.point_y;
            n_prod[r][2] = $signed(i_cfg[2*r+1][31:0]) * r_in.point_z;
            n_prod[r][3] = {{16{i_cfg[2*r+1][63]}}, i_cfg[2*r+1][63:32],
                            {ppp_pkg::FRAC_W{1'b0}}};
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_pair[r][0] = {r_prod[r][0][ppp_pkg::PROD_W-1], r_prod[r][0]}
                         + {r_prod[r][1][ppp_pkg::PROD_W-1], r_prod[r][1]};
            n_pair[r][1] = {r_prod[r][2][ppp_pkg::PROD_W-1], r_prod[r][2]}
                         + {r_prod[r][3][ppp_pkg::PROD_W-1], r_prod[r][3]};
        end
    end

    // round half up to Q16.16
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = {r_pair[r][0][ppp_pkg::PAIR_W-1], r_pair[r][0]}
                     + {r_pair[r][1][ppp_pkg::PAIR_W-1], r_pair[r][1]}
                     + ppp_pkg::SUM_W'(32768);
        end
        n_homog.hx = n_sum[0][ppp_pkg::SUM_W-1:ppp_pkg::FRAC_W];
        n_homog.hy = n_sum[1][ppp_pkg::SUM_W-1:ppp_pkg::FRAC_W];
        n_homog.hw = n_sum[2][ppp_pkg::SUM_W-1:ppp_pkg::FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_in <= i_word;
        end
        if (rdy[1]) begin
            r_prod <= n_prod;
        end
        if (rdy[2]) begin
            r_pair <= n_pair;
        end
        if (rdy[3]) begin
            r_homog <= n_homog;
        end
    end

endmodule

[rtl/ppp_div.sv]
// pipelined restoring divider for both pixel coordinates with rounding and saturation
`timescale 1ns / 1ps

module ppp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ppp_pkg::t_homog    i_homog,
    output logic               o_valid,
    input  logic               i_ready,
    output ppp_pkg::t_out_word o_word
);

    localparam int NSTEP = ppp_pkg::QUO_W;
    localparam int NSTG  = NSTEP + 3;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   rdy;

    ppp_pkg::t_div_stage r_stg [NSTG-1];
    ppp_pkg::t_div_stage n_stg [NSTG-1];
    ppp_pkg::t_out_word  r_out;
    ppp_pkg::t_out_word  n_out;

    logic [ppp_pkg::HOM_W-1:0] abs_x;
    logic [ppp_pkg::HOM_W-1:0] abs_y;
    logic [ppp_pkg::HOM_W-1:0] abs_w;

    function automatic logic [ppp_pkg::COORD_W-1:0] lane_fin(
        input logic [ppp_pkg::QUO_W-1:0] q,
        input logic                      neg,
        input logic                      ovf
    );
        logic [ppp_pkg::COORD_W-1:0] mag;
        logic [ppp_pkg::COORD_W-1:0] res;
        mag = {1'b0, q[ppp_pkg::QUO_W-1:1]} + {{(ppp_pkg::COORD_W-1){1'b0}}, q[0]};
        if (ovf) begin
            res = neg ? ppp_pkg::S32_MIN : ppp_pkg::S32_MAX;
        end else if (neg) begin
            res = mag[ppp_pkg::COORD_W-1] ? ppp_pkg::S32_MIN : (~mag + 1'b1);
        end else begin
            res = mag[ppp_pkg::COORD_W-1] ? ppp_pkg::S32_MAX : mag;
        end
        return res;
    endfunction

    assign rdy[NSTG] = i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end
    assign o_ready = rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_word  = r_out;

    // magnitudes, signs, zero test, depth saturation
    always_comb begin
        abs_x = i_homog.hx[ppp_pkg::HOM_W-1] ? (~i_homog.hx + 1'b1) : i_homog.hx;
        abs_y = i_homog.hy[ppp_pkg::HOM_W-1] ? (~i_homog.hy + 1'b1) : i_homog.hy;
        abs_w = i_homog.hw[ppp_pkg::HOM_W-1] ? (~i_homog.hw + 1'b1) : i_homog.hw;
        n_stg[0]       = '0;
        n_stg[0].n_x   = abs_x[ppp_pkg::MAG_W-1:0];
        n_stg[0].n_y   = abs_y[ppp_pkg::MAG_W-1:0];
        n_stg[0].d     = abs_w[ppp_pkg::MAG_W-1:0];
        n_stg[0].neg_x = i_homog.hx[ppp_pkg::HOM_W-1] ^ i_homog.hw[ppp_pkg::HOM_W-1];
        n_stg[0].neg_y = i_homog.hy[ppp_pkg::HOM_W-1] ^ i_homog.hw[ppp_pkg::HOM_W-1];
        n_stg[0].zd    = (i_homog.hw == '0);
        if ((&i_homog.hw[ppp_pkg::HOM_W-1:ppp_pkg::COORD_W-1])
            || !(|i_homog.hw[ppp_pkg::HOM_W-1:ppp_pkg::COORD_W-1])) begin
            n_stg[0].depth = i_homog.hw[ppp_pkg::COORD_W-1:0];
        end else begin
            n_stg[0].depth = i_homog.hw[ppp_pkg::HOM_W-1] ? ppp_pkg::S32_MIN
                                                          : ppp_pkg::S32_MAX;
        end
    end

    // integer part overflow check and remainder seed
    always_comb begin
        n_stg[1]       = r_stg[0];
        n_stg[1].ovf_x = ({{ppp_pkg::OVF_SH{1'b0}}, r_stg[0].n_x}
                          >= {r_stg[0].d, {ppp_pkg::OVF_SH{1'b0}}});
        n_stg[1].ovf_y = ({{ppp_pkg::OVF_SH{1'b0}}, r_stg[0].n_y}
                          >= {r_stg[0].d, {ppp_pkg::OVF_SH{1'b0}}});
        n_stg[1].r_x   = r_stg[0].n_x >> ppp_pkg::OVF_SH;
        n_stg[1].r_y   = r_stg[0].n_y >> ppp_pkg::OVF_SH;
        n_stg[1].q_x   = '0;
        n_stg[1].q_y   = '0;
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int B = NSTEP - 1 - s;
        logic                     nb_x;
        logic                     nb_y;
        logic [ppp_pkg::MAG_W:0]   t_x;
        logic [ppp_pkg::MAG_W:0]   t_y;
        logic [ppp_pkg::MAG_W+1:0] df_x;
        logic [ppp_pkg::MAG_W+1:0] df_y;

        if (B >= ppp_pkg::EXTRA_SH) begin : g_feed
            assign nb_x = r_stg[s+1].n_x[B-ppp_pkg::EXTRA_SH];
            assign nb_y = r_stg[s+1].n_y[B-ppp_pkg::EXTRA_SH];
        end else begin : g_zero
            assign nb_x = 1'b0;
            assign nb_y = 1'b0;
        end

        always_comb begin
            t_x  = {r_stg[s+1].r_x, nb_x};
            t_y  = {r_stg[s+1].r_y, nb_y};
            df_x = {1'b0, t_x} - {2'b00, r_stg[s+1].d};
            df_y = {1'b0, t_y} - {2'b00, r_stg[s+1].d};
            n_stg[s+2] = r_stg[s+1];
            if (!df_x[ppp_pkg::MAG_W+1]) begin
                n_stg[s+2].r_x    = df_x[ppp_pkg::MAG_W-1:0];
                n_stg[s+2].q_x[B] = 1'b1;
            end else begin
                n_stg[s+2].r_x = t_x[ppp_pkg::MAG_W-1:0];
            end
            if (!df_y[ppp_pkg::MAG_W+1]) begin
                n_stg[s+2].r_y    = df_y[ppp_pkg::MAG_W-1:0];
                n_stg[s+2].q_y[B] = 1'b1;
            end else begin
                n_stg[s+2].r_y = t_y[ppp_pkg::MAG_W-1:0];
            end
        end
    end

    always_comb begin
        n_out.depth      = r_stg[NSTG-2].depth;
        n_out.zero_depth = r_stg[NSTG-2].zd;
        if (r_stg[NSTG-2].zd) begin
            n_out.pixel_x = '0;
            n_out.pixel_y = '0;
            n_out.depth   = '0;
        end else begin
            n_out.pixel_x = lane_fin(r_stg[NSTG-2].q_x, r_stg[NSTG-2].neg_x,
                                     r_stg[NSTG-2].ovf_x);
            n_out.pixel_y = lane_fin(r_stg[NSTG-2].q_y, r_stg[NSTG-2].neg_y,
                                     r_stg[NSTG-2].ovf_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG-1; k++) begin
            if (rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (rdy[NSTG-1]) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/pinhole_point_projector_core.sv]
// top level of the pinhole point projector: matrix registers, dot product and divider pipes
`timescale 1ns / 1ps

// Projects one Q16.16 world point per clock, unless stalled, through a 3x4 camera
// matrix held in six 64-bit registers, giving pixel x/y = X/W, Y/W and the depth W,
// all saturated to signed Q16.16, with zero_depth set when W is exactly zero. A new
// word can be taken every cycle unless stalled. The pipe has 4 stages for input
// capture, products, pair sums and rounded sum, then 35 in the divider, which
// resolves one quotient bit per stage (32 stages) between two setup stages and the
// rounding/saturation output register. Stalls are absorbed by empty pipeline stages
// before the input is held off. Matrix registers act on the datapath directly; the
// user must write them only while the pipe is empty; the block does not enforce it.

module pinhole_point_projector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ppp_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ppp_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_wr_en,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]        i_cfg_data
);

    ppp_pkg::t_cfg_regs r_cfg;
    logic               dot_ready;
    logic               dot_valid;
    logic               div_ready;
    ppp_pkg::t_homog    dot_homog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ppp_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (ppp_pkg::t_cfg_idx'(i_cfg_index))
                ppp_pkg::CFG_ROW0_C01: r_cfg[ppp_pkg::CFG_ROW0_C01] <= i_cfg_data;
                ppp_pkg::CFG_ROW0_C23: r_cfg[ppp_pkg::CFG_ROW0_C23] <= i_cfg_data;
                ppp_pkg::CFG_ROW1_C01: r_cfg[ppp_pkg::CFG_ROW1_C01] <= i_cfg_data;
                ppp_pkg::CFG_ROW1_C23: r_cfg[ppp_pkg::CFG_ROW1_C23] <= i_cfg_data;
                ppp_pkg::CFG_ROW2_C01: r_cfg[ppp_pkg::CFG_ROW2_C01] <= i_cfg_data;
                ppp_pkg::CFG_ROW2_C23: r_cfg[ppp_pkg::CFG_ROW2_C23] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = !dot_ready;

    ppp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (dot_ready),
        .i_word  (i_in_word),
        .o_valid (dot_valid),
        .i_ready (div_ready),
        .o_homog (dot_homog)
    );

    ppp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dot_valid),
        .o_ready (div_ready),
        .i_homog (dot_homog),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

[rtl/ppp_checker.sv]
// port level checks for the point projector, bound to the top level
`timescale 1ns / 1ps

module ppp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input ppp_pkg::t_out_word            o_out_word
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_zero_depth_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.zero_depth |->
            o_out_word.pixel_x == '0 && o_out_word.pixel_y == '0
            && o_out_word.depth == '0)
        else $error("zero depth word with nonzero fields");

    a_depth_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.depth != '0 |-> !o_out_word.zero_depth)
        else $error("zero depth flag on nonzero depth");

    a_in_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output drains");

endmodule

bind pinhole_point_projector_core ppp_checker u_ppp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

[tb/tb_top.sv]
// self-checking testbench for the pinhole point projector core
`timescale 1ns / 1ps

module tb_top;

    typedef enum int {MX_CAMERA, MX_SMALL, MX_FULL} t_mx_style;

    localparam logic [ppp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [ppp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam logic [ppp_pkg::COORD_W-1:0]   Q_ONE            = 32'h0001_0000;
    localparam int                            RAND_PHASES      = 8;
    localparam int                            POINTS_PER_PHASE = 250;
    localparam int                            CYCLE_LIMIT      = 600000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    ppp_pkg::t_in_word             i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    ppp_pkg::t_out_word            o_out_word;
    logic                          i_cfg_wr_en = 1'b0;
    logic [ppp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ppp_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    ppp_pkg::t_cfg_regs  cfg_model = ppp_pkg::CFG_RESET;
    ppp_pkg::t_out_word  pending_projections[$];
    ppp_pkg::t_out_word  want;
    bit         in_quiet;
    bit         out_quiet;
    int         points_sent;
    int         pixels_checked;
    int         matrix_loads;
    int         mismatch_count;
    int         cycle_count;

    pinhole_point_projector_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one matrix row against (x, y, z, 1), exact, then rounded half up to wide q16.16
    function automatic logic signed [63:0] dot_row(input logic [ppp_pkg::CFG_W-1:0] c01, c23,
                                                   input ppp_pkg::t_in_word p);
        logic signed [79:0] m0, m1, m2, m3, px, py, pz, acc;
        m0  = $signed(c01[31:0]);
        m1  = $signed(c01[63:32]);
        m2  = $signed(c23[31:0]);
        m3  = $signed(c23[63:32]);
        px  = $signed(p.point_x);
        py  = $signed(p.point_y);
        pz  = $signed(p.point_z);
        acc = m0 * px + m1 * py + m2 * pz + m3 * 80'sd65536 + 80'sd32768;
        return 64'(acc >>> 16);
    endfunction

    // q16.16 quotient, rounded half away from zero, saturated
    function automatic logic [31:0] q16_div(input logic signed [63:0] num, den);
        logic [63:0]  n, d;
        logic [127:0] scaled, quo, rem;
        logic         neg;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        if (n == 0)
            return '0;
        if (n / d >= 64'd32768)
            return neg ? ppp_pkg::S32_MIN : ppp_pkg::S32_MAX;
        scaled = {64'd0, n} << 16;
        quo    = scaled / {64'd0, d};
        rem    = scaled % {64'd0, d};
        if ((rem << 1) >= {64'd0, d})
            quo = quo + 128'd1;
        if (neg)
            return (quo >= 128'h8000_0000) ? ppp_pkg::S32_MIN : 32'd0 - quo[31:0];
        return (quo > 128'h7FFF_FFFF) ? ppp_pkg::S32_MAX : quo[31:0];
    endfunction

    function automatic ppp_pkg::t_out_word project_point(input ppp_pkg::t_in_word p);
        logic signed [63:0] hx, hy, hw;
        ppp_pkg::t_out_word r;
        hx = dot_row(cfg_model[ppp_pkg::CFG_ROW0_C01], cfg_model[ppp_pkg::CFG_ROW0_C23], p);
        hy = dot_row(cfg_model[ppp_pkg::CFG_ROW1_C01], cfg_model[ppp_pkg::CFG_ROW1_C23], p);
        hw = dot_row(cfg_model[ppp_pkg::CFG_ROW2_C01], cfg_model[ppp_pkg::CFG_ROW2_C23], p);
        r  = '0;
        if (hw == 0) begin
            r.zero_depth = 1'b1;
        end else begin
            r.pixel_x = q16_div(hx, hw);
            r.pixel_y = q16_div(hy, hw);
            if (hw > 64'sd2147483647)
                r.depth = ppp_pkg::S32_MAX;
            else if (hw < -64'sd2147483648)
                r.depth = ppp_pkg::S32_MIN;
            else
                r.depth = hw[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_span(input int unsigned half);
        return 32'($urandom_range(0, 2 * half)) - 32'(half);
    endfunction

    function automatic logic [31:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return rand_span(32'h40_0000);
        if (pick < 9)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ppp_pkg::S32_MAX;
            2:       return ppp_pkg::S32_MIN;
            3:       return Q_ONE;
            default: return 32'd0 - Q_ONE;
        endcase
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v, got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_projections.size() == 0) begin
                $error("output word with no projection pending");
                mismatch_count++;
            end else begin
                want = pending_projections.pop_front();
                pixels_checked++;
                report_field("pixel_x", want.pixel_x, o_out_word.pixel_x);
                report_field("pixel_y", want.pixel_y, o_out_word.pixel_y);
                report_field("depth", want.depth, o_out_word.depth);
                report_field("zero_depth", 32'(want.zero_depth), 32'(o_out_word.zero_depth));
            end
        end
    end

    // output side stall
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            hold = out_quiet ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic send_point(input ppp_pkg::t_in_word p);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= p;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_projections.insert(pending_projections.size(), project_point(p));
        points_sent++;
    endtask

    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_projections.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [ppp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppp_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx < ppp_pkg::NUM_CFG)
            cfg_model[idx] = data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_cfg(input ppp_pkg::t_cfg_regs r);
        drain_pipe();
        for (int k = 0; k < ppp_pkg::NUM_CFG; k++)
            write_cfg(ppp_pkg::CFG_IDX_W'(k), r[k]);
        matrix_loads++;
    endtask

    task automatic test_identity_points();
        send_point({Q_ONE, 32'h0002_0000, Q_ONE});
        send_point({32'h0, 32'h0, 32'h0});
        send_point({32'h0005_0000, 32'hFFFD_0000, 32'h0});
        send_point({32'h0, 32'h0007_0000, 32'h0002_0000});
        send_point({ppp_pkg::S32_MAX, ppp_pkg::S32_MIN, 32'h1});
        send_point({ppp_pkg::S32_MIN, ppp_pkg::S32_MAX, 32'hFFFF_FFFF});
        send_point({ppp_pkg::S32_MAX, ppp_pkg::S32_MAX, ppp_pkg::S32_MAX});
        send_point({ppp_pkg::S32_MIN, ppp_pkg::S32_MIN, ppp_pkg::S32_MIN});
        send_point({32'h1, 32'hFFFF_FFFF, 32'h0002_0000});
        send_point({32'h3, 32'hFFFF_FFFD, 32'h0004_0000});
    endtask

    task automatic test_wide_depth();
        ppp_pkg::t_cfg_regs r;
        r = {ppp_pkg::NUM_CFG{64'h8000_0000_8000_0000}};
        load_cfg(r);
        send_point({ppp_pkg::S32_MIN, ppp_pkg::S32_MIN, ppp_pkg::S32_MIN});
        send_point({ppp_pkg::S32_MAX, ppp_pkg::S32_MAX, ppp_pkg::S32_MAX});
        send_point({32'h0, 32'h0, 32'h0});
        r = {ppp_pkg::NUM_CFG{64'hFFFF_FFFF_FFFF_FFFF}};
        load_cfg(r);
        send_point({ppp_pkg::S32_MAX, ppp_pkg::S32_MIN, 32'h1});
        send_point({32'h0, 32'h0, 32'h0});
        r = {ppp_pkg::NUM_CFG{64'h7FFF_FFFF_7FFF_FFFF}};
        load_cfg(r);
        send_point({ppp_pkg::S32_MIN, ppp_pkg::S32_MIN, ppp_pkg::S32_MIN});
        send_point({ppp_pkg::S32_MAX, 32'h0, ppp_pkg::S32_MAX});
        // depth row of one lsb: rounding decides between zero and one
        r = ppp_pkg::CFG_RESET;
        r[ppp_pkg::CFG_ROW2_C01] = 64'h0000_0000_0000_0001;
        r[ppp_pkg::CFG_ROW2_C23] = '0;
        load_cfg(r);
        send_point({32'h1, 32'h1, 32'h1});
        send_point({32'h8000, 32'h1_0000, 32'h0});
        send_point({32'hFFFF_8000, 32'h1_0000, 32'h0});
        // depth cancels to zero
        r[ppp_pkg::CFG_ROW2_C01] = {32'd0 - Q_ONE, Q_ONE};
        load_cfg(r);
        send_point({32'h0007_0000, 32'h0007_0000, 32'h0003_0000});
    endtask

    task automatic test_spare_index();
        load_cfg(ppp_pkg::CFG_RESET);
        write_cfg(CFG_IDX_SPARE_LO, {ppp_pkg::CFG_W{1'b1}});
        write_cfg(CFG_IDX_SPARE_HI, 64'h8000_0000_8000_0000);
        send_point({32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000});
        send_point({32'h0, Q_ONE, 32'h0});
    endtask

    task automatic test_random_stream();
        ppp_pkg::t_cfg_regs r;
        t_mx_style          style;
        int                 ph;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            style = t_mx_style'(ph % 3);
            case (style)
                MX_CAMERA: begin
                    r[ppp_pkg::CFG_ROW0_C01] = {rand_span(1 << 15),
                                                32'($urandom_range(100, 2000)) << 16};
                    r[ppp_pkg::CFG_ROW0_C23] = {rand_span(1 << 26),
                                                32'($urandom_range(0, 1920)) << 16};
                    r[ppp_pkg::CFG_ROW1_C01] = {32'($urandom_range(100, 2000)) << 16,
                                                rand_span(1 << 15)};
                    r[ppp_pkg::CFG_ROW1_C23] = {rand_span(1 << 26),
                                                32'($urandom_range(0, 1080)) << 16};
                    r[ppp_pkg::CFG_ROW2_C01] = {rand_span(1 << 14), rand_span(1 << 14)};
                    r[ppp_pkg::CFG_ROW2_C23] = {rand_span(1 << 22),
                                                Q_ONE + rand_span(1 << 13)};
                end
                MX_SMALL: begin
                    for (int k = 0; k < ppp_pkg::NUM_CFG; k++)
                        r[k] = {rand_span(4 << 16), rand_span(4 << 16)};
                end
                default: begin
                    for (int k = 0; k < ppp_pkg::NUM_CFG; k++)
                        r[k] = {$urandom, $urandom};
                end
            endcase
            load_cfg(r);
            in_quiet  = (ph % 4 == 1) || (ph == RAND_PHASES - 1);
            out_quiet = (ph % 4 == 2) || (ph == RAND_PHASES - 1);
            for (int i = 0; i < POINTS_PER_PHASE; i++) begin
                // hold the sender until the pipe has fully emptied
                if (ph == 4 && i == POINTS_PER_PHASE / 2)
                    drain_pipe();
                send_point({rand_coord(), rand_coord(), rand_coord()});
            end
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_identity_points();
        test_wide_depth();
        test_spare_index();
        test_random_stream();
        drain_pipe();
        repeat (60) @(posedge i_clk);
        $display("projected %0d points under %0d matrix loads, %0d output words checked",
                 points_sent, matrix_loads, pixels_checked);
        $display("covered saturation, zero depth, rounding edges, spare register indexes");
        if (mismatch_count == 0 && pending_projections.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/ppp_pkg.sv
rtl/ppp_dot.sv
rtl/ppp_div.sv
rtl/pinhole_point_projector_core.sv
rtl/ppp_checker.sv
tb/tb_top.sv
